FILE: rtl/cul_pkg.sv
// ----------------------------------------------------------------------------
// cul_pkg
// types and request codes shared by the compacting unique list core
// ----------------------------------------------------------------------------
package cul_pkg;

   // request codes
   localparam logic [2:0] REQ_INSERT        = 3'd0;
   localparam logic [2:0] REQ_REMOVE_AT     = 3'd1;
   localparam logic [2:0] REQ_REMOVE_HANDLE = 3'd2;
   localparam logic [2:0] REQ_READ          = 3'd3;
   localparam logic [2:0] REQ_CLEAR         = 3'd4;

   localparam int unsigned HANDLE_W = 16;
   localparam int unsigned COUNT_W  = 5;

   typedef struct packed {
      logic [2:0]                 req_type;
      logic [HANDLE_W-1:0]        handle;
      logic signed [HANDLE_W-1:0] position;
   } req_item_type;

   typedef struct packed {
      logic                ok;
      logic [HANDLE_W-1:0] read_handle;
      logic [COUNT_W-1:0]  entry_count;
   } rsp_item_type;

endpackage

FILE: rtl/cul_ram.sv
// ----------------------------------------------------------------------------
// cul_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module cul_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/compacting_unique_list_core.sv
// ----------------------------------------------------------------------------
// compacting_unique_list_core
// dense ordered list of unique handles held in a ram, with insert, remove at
// index, remove by handle, clamped read and clear
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+----------------------------
//   req     | in        | req_valid / req_ready | cul_pkg::req_item_type
//   rsp     | out       | rsp_valid / rsp_ready | cul_pkg::rsp_item_type
//
// one item is worked at a time; the ram read port (one entry a cycle, registered
// read) carries the search and compaction passes:
//   insert, remove by handle: the entries are searched from slot 0 until the
//   handle is found or the whole list is read; insert appends an absent handle
//   and refuses a present one; removal by handle shifts the later entries one
//   slot down through the same port
//   remove at index i: the entries after slot i shift one slot down; read: a
//   single ram read at the clamped index; clear and items refused without a
//   search: no ram pass
// reset clears count and control only; ram contents are never read past the
// count, so no clearing pass is needed and clear just zeroes the count
// the next item is taken as soon as a result is parked in the output register,
// and a stalled rsp side holds the block in its response state
// ----------------------------------------------------------------------------
module compacting_unique_list_core #(
   parameter int unsigned CAPACITY = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cul_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output cul_pkg::rsp_item_type rsp_data
);

   import cul_pkg::*;

   // address width and width of a counter that can hold the capacity itself
   localparam int unsigned AW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_READ,
      ST_READ_DATA,
      ST_RESP
   } state_type;

   state_type           state_ff, state_in;
   logic [2:0]          op_ff, op_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [CW-1:0]       cur_ff, cur_in;        // next ram entry to read
   logic                pend_ff, pend_in;      // a read is in flight
   logic [CW-1:0]       pend_idx_ff, pend_idx_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                res_ok_ff, res_ok_in;
   logic [HANDLE_W-1:0] res_rd_ff, res_rd_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_item_type        rsp_ff, rsp_in;

   // ram port signals
   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [HANDLE_W-1:0] ram_wdata;
   logic                ram_re;
   logic [HANDLE_W-1:0] ram_rdata;

   // request decode helpers
   logic [HANDLE_W-1:0] pos_u;
   logic                pos_in_range;
   logic [CW-1:0]       read_idx;
   logic                issue;
   logic [CW-1:0]       shift_dst;

   cul_ram #(
      .WIDTH (HANDLE_W),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (cur_ff[AW-1:0]),
      .rd_data (ram_rdata)
   );

   // index checks on the incoming position
   assign pos_u        = HANDLE_W'(req_data.position);
   assign pos_in_range = !pos_u[HANDLE_W-1] && (pos_u < HANDLE_W'(count_ff));

   always_comb begin
      priority if (pos_u[HANDLE_W-1]) begin
         read_idx = '0;
      end else if (pos_u >= HANDLE_W'(count_ff)) begin
         read_idx = count_ff - CW'(1);
      end else begin
         read_idx = pos_u[CW-1:0];
      end
   end

   // more entries left to stream through the read port
   assign issue     = (cur_ff < count_ff);
   // compaction moves the entry read last cycle one slot down
   assign shift_dst = pend_idx_ff - CW'(1);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      handle_in    = handle_ff;
      cur_in       = cur_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      count_in     = count_ff;
      res_ok_in    = res_ok_ff;
      res_rd_in    = res_rd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_waddr    = count_ff[AW-1:0];
      ram_wdata    = handle_ff;
      ram_re       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in     = req_data.req_type;
               handle_in = req_data.handle;
               pend_in   = 1'b0;
               res_ok_in = 1'b0;
               res_rd_in = '0;
               cur_in    = '0;
               state_in  = ST_RESP;
               unique case (req_data.req_type)
                  REQ_INSERT: begin
                     // a full list refuses without a search
                     if (count_ff != CW'(CAPACITY)) begin
                        state_in = ST_SCAN;
                     end
                  end
                  REQ_REMOVE_AT: begin
                     if (pos_in_range) begin
                        cur_in   = pos_u[CW-1:0] + CW'(1);
                        state_in = ST_SHIFT;
                     end
                  end
                  REQ_REMOVE_HANDLE: begin
                     state_in = ST_SCAN;
                  end
                  REQ_READ: begin
                     // empty list answers zero with ok clear
                     if (count_ff != '0) begin
                        cur_in   = read_idx;
                        state_in = ST_READ;
                     end
                  end
                  REQ_CLEAR: begin
                     count_in  = '0;
                     res_ok_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SCAN: begin
            ram_re = issue;
            if (pend_ff && (ram_rdata == handle_ff)) begin
               // handle present
               pend_in = 1'b0;
               if (op_ff == REQ_REMOVE_HANDLE) begin
                  cur_in   = pend_idx_ff + CW'(1);
                  state_in = ST_SHIFT;
               end else begin
                  state_in = ST_RESP;
               end
            end else if (!issue && !pend_ff) begin
               // whole list searched, handle absent
               if (op_ff == REQ_INSERT) begin
                  ram_we    = 1'b1;
                  count_in  = count_ff + CW'(1);
                  res_ok_in = 1'b1;
               end
               state_in = ST_RESP;
            end else begin
               pend_in     = issue;
               pend_idx_in = cur_ff;
               if (issue) begin
                  cur_in = cur_ff + CW'(1);
               end
            end
         end

         ST_SHIFT: begin
            ram_re = issue;
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = shift_dst[AW-1:0];
               ram_wdata = ram_rdata;
            end
            if (!issue && !pend_ff) begin
               count_in  = count_ff - CW'(1);
               res_ok_in = 1'b1;
               state_in  = ST_RESP;
            end else begin
               pend_in     = issue;
               pend_idx_in = cur_ff;
               if (issue) begin
                  cur_in = cur_ff + CW'(1);
               end
            end
         end

         ST_READ: begin
            ram_re   = 1'b1;
            state_in = ST_READ_DATA;
         end

         ST_READ_DATA: begin
            res_rd_in = ram_rdata;
            res_ok_in = 1'b1;
            state_in  = ST_RESP;
         end

         ST_RESP: begin
            // park the result once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_in.ok          = res_ok_ff;
               rsp_in.read_handle = res_rd_ff;
               rsp_in.entry_count = COUNT_W'(count_ff);
               state_in           = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      handle_ff   <= handle_in;
      cur_ff      <= cur_in;
      pend_idx_ff <= pend_idx_in;
      res_ok_ff   <= res_ok_in;
      res_rd_ff   <= res_rd_in;
      rsp_ff      <= rsp_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // list never grows past its capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   // clear empties the list on the following cycle
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_data.req_type == REQ_CLEAR)) |=> (count_ff == '0))
      else $error("clear did not empty the list");

   // the ram is written only while an item is being worked
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !ram_we)
      else $error("ram written while idle");

   // compaction never moves an entry onto a slot below zero
   a_shift_source: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SHIFT) && pend_ff) |-> (pend_idx_ff != '0))
      else $error("compaction read from slot zero");

   // count holds steady while a read is in progress or a result is being formed
   a_count_steady: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP || state_ff == ST_READ || state_ff == ST_READ_DATA)
         |=> $stable(count_ff))
      else $error("count changed outside an update");

endmodule
